FILE: src/gmf_pkg.sv
// ----------------------------------------------------------------------------
// gmf_pkg
// Shared constants and controller/datapath handshake types for the
// Gabor magnitude filter.
// ----------------------------------------------------------------------------
package gmf_pkg;

   localparam int KERNEL_RADIUS_DEF = 4;
   localparam int MAX_WIDTH_DEF     = 1024;

   localparam int CMD_W    = 2;
   localparam int IDX_W    = 7;
   localparam int COEF_W   = 18;
   localparam int PIX_W    = 8;
   localparam int MAG_W    = 24;
   localparam int POS_W    = 10;
   localparam int DIM_W    = 11;
   localparam int CNT_W    = 21;
   localparam int CSR_IDX_W = 1;

   localparam int HLIMIT         = 1024;
   localparam int FRAME_W_RESET  = 640;
   localparam int FRAME_H_RESET  = 480;
   localparam logic [MAG_W-1:0] MAG_MAX = '1;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   typedef struct packed {
      logic take_item;
      logic latch_size;
      logic store_pixel;
      logic mac_start;
      logic square;
      logic sqrt_start;
      logic emit;
   } gmf_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             recv_zero;
      logic             frame_full;
      logic             emit_ready;
      logic             mac_busy;
      logic             sqrt_busy;
      logic             out_free;
      logic             frame_last;
   } gmf_status_type;

endpackage

FILE: src/gmf_req_if.sv
// ----------------------------------------------------------------------------
// gmf_req_if
// Request channel: coefficient loads, pixels and flush slots.
// ----------------------------------------------------------------------------
interface gmf_req_if
   import gmf_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic [IDX_W-1:0]         coef_index;
   logic signed [COEF_W-1:0] coef_real;
   logic signed [COEF_W-1:0] coef_imag;
   logic [PIX_W-1:0]         pixel;

   modport source (output valid, command, coef_index, coef_real, coef_imag, pixel,
                   input ready);
   modport sink   (input valid, command, coef_index, coef_real, coef_imag, pixel,
                   output ready);
endinterface

FILE: src/gmf_rsp_if.sv
// ----------------------------------------------------------------------------
// gmf_rsp_if
// Response channel: one magnitude with its output position.
// ----------------------------------------------------------------------------
interface gmf_rsp_if
   import gmf_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [MAG_W-1:0] magnitude;
   logic [POS_W-1:0] out_col;
   logic [POS_W-1:0] out_row;
   logic             frame_end;

   modport source (output valid, magnitude, out_col, out_row, frame_end, input ready);
   modport sink   (input valid, magnitude, out_col, out_row, frame_end, output ready);
endinterface

FILE: src/gabor_magnitude_filter.sv
// ----------------------------------------------------------------------------
// gabor_magnitude_filter
// Streaming Gabor magnitude over a raster of 8-bit pixels.
// ----------------------------------------------------------------------------
// One request is worked at a time. A coefficient load writes the table; a
// pixel latches the frame size if it is the first of a frame, is stored in
// the line store and is then checked for a due output, as a flush is. For a
// due output the window MAC reads the line store and coefficient table one
// tap per cycle, the real and imaginary sums are squared and added, and the
// root unit retires two radicand bits per cycle. A finished result sits in
// the output register, and the next request is taken while it waits.
// The first outputs of a frame lag the input by R rows plus R+1 pixels, with
// R the kernel radius; flush requests drain the rest after the last pixel.
// ----------------------------------------------------------------------------
module gabor_magnitude_filter
   import gmf_pkg::*;
#(
   parameter int KERNEL_RADIUS = KERNEL_RADIUS_DEF,
   parameter int MAX_WIDTH     = MAX_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   gmf_req_if.sink              req_if,
   gmf_rsp_if.source            rsp_if,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wr_data
);

   gmf_cmd_type    cmd;
   gmf_status_type status;
   logic           req_ready;

   gmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_if.ready = req_ready;

   gmf_datapath #(
      .KERNEL_RADIUS (KERNEL_RADIUS),
      .MAX_WIDTH     (MAX_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

   // never overwrite a result that has not been transferred
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result loaded over a pending transfer");

   // the window MAC only starts for an output that is due
   a_mac_due: assert property (@(posedge clock) disable iff (reset)
      cmd.mac_start |-> status.emit_ready)
      else $error("window MAC started with no output due");

   // the last output of a frame rewinds the position counters
   a_frame_rewind: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.frame_last) |=> (status.recv_zero && rsp_if.frame_end))
      else $error("frame end did not rewind positions");

endmodule

FILE: src/gmf_ctrl.sv
// ----------------------------------------------------------------------------
// gmf_ctrl
// Sequencer: takes one request at a time and steps the datapath through
// size latch, pixel store, window MAC, squaring, root and output.
// ----------------------------------------------------------------------------
module gmf_ctrl
   import gmf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  gmf_status_type status,
   output gmf_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_LATCH, S_STORE, S_CHECK, S_MAC, S_SQUARE, S_SUM, S_SQRT, S_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_item = 1'b1;
               case (status.command)
                  CMD_PIXEL: state_in = status.recv_zero ? S_LATCH : S_STORE;
                  CMD_FLUSH: state_in = S_CHECK;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_LATCH: begin
            cmd.latch_size = 1'b1;
            state_in       = S_STORE;
         end
         S_STORE: begin
            // drop pixels once the frame is fully received
            if (status.frame_full) begin
               state_in = S_IDLE;
            end else begin
               cmd.store_pixel = 1'b1;
               state_in        = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.emit_ready) begin
               cmd.mac_start = 1'b1;
               state_in      = S_MAC;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MAC: begin
            if (!status.mac_busy) state_in = S_SQUARE;
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = S_SUM;
         end
         S_SUM: begin
            cmd.sqrt_start = 1'b1;
            state_in       = S_SQRT;
         end
         S_SQRT: begin
            if (!status.sqrt_busy) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/gmf_sqrt.sv
// ----------------------------------------------------------------------------
// gmf_sqrt
// Floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module gmf_sqrt
   import gmf_pkg::*;
#(
   parameter int WIDTH = 46
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [WIDTH-1:0]   operand,
   output logic               busy,
   output logic [WIDTH/2-1:0] root
);

   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] res_ff, res_in;
   logic [WIDTH-1:0] one_ff, one_in;
   logic             busy_ff, busy_in;
   logic [WIDTH-1:0] trial;

   always_comb begin
      trial   = res_ff + one_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      one_in  = one_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = operand;
         res_in  = '0;
         one_in  = {2'b01, {(WIDTH-2){1'b0}}};
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + one_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         one_in = one_ff >> 2;
         if (one_ff[0]) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      one_ff <= one_in;
   end

   assign busy = busy_ff;
   assign root = res_ff[WIDTH/2-1:0];

endmodule

FILE: src/gmf_datapath.sv
// ----------------------------------------------------------------------------
// gmf_datapath
// Line store, coefficient tables, position counters, window MAC, squaring,
// root and the output register.
// ----------------------------------------------------------------------------
module gmf_datapath
   import gmf_pkg::*;
#(
   parameter int KERNEL_RADIUS = KERNEL_RADIUS_DEF,
   parameter int MAX_WIDTH     = MAX_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   gmf_req_if.sink              req_if,
   gmf_rsp_if.source            rsp_if,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wr_data,
   input  gmf_cmd_type          cmd,
   output gmf_status_type       status
);

   localparam int KSIZE    = 2 * KERNEL_RADIUS + 1;
   localparam int KAREA    = KSIZE * KSIZE;
   localparam int LS_ROWS  = 2 * KERNEL_RADIUS + 2;
   localparam int LS_DEPTH = LS_ROWS * MAX_WIDTH;
   localparam int LS_AW    = $clog2(LS_DEPTH);
   localparam int SLOT_W   = $clog2(LS_ROWS);
   localparam int KW       = $clog2(KSIZE);
   localparam int KA_W     = $clog2(KAREA);
   localparam int WLIMIT   = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
   localparam int ACC_W    = 26 + $clog2(KAREA);
   localparam int Q4_W     = ACC_W - 10;
   localparam int SQ_W     = 2 * Q4_W;
   localparam int RW       = (Q4_W > MAG_W) ? Q4_W : MAG_W;
   localparam int RST_W    = (FRAME_W_RESET < WLIMIT) ? FRAME_W_RESET : WLIMIT;
   localparam int RST_TOTAL = RST_W * FRAME_H_RESET;
   localparam int RST_LAG   = KERNEL_RADIUS * RST_W + KERNEL_RADIUS + 1;
   localparam logic signed [11:0] RAD_S   = 12'(KERNEL_RADIUS);
   localparam logic signed [11:0] ROWS_S  = 12'(LS_ROWS);

   // configuration and latched frame size
   logic [DIM_W-1:0] frame_width_ff, frame_height_ff;
   logic [DIM_W-1:0] lat_w_ff, lat_h_ff;
   logic [CNT_W-1:0] total_ff, lag_ff;
   logic [DIM_W-1:0] w_cl, h_cl;

   // positions
   logic [POS_W-1:0]  in_col_ff, in_col_in, in_row_ff, in_row_in;
   logic [SLOT_W-1:0] in_slot_ff, in_slot_in;
   logic [POS_W-1:0]  emit_col_ff, emit_col_in, emit_row_ff, emit_row_in;
   logic [SLOT_W-1:0] emit_slot_ff, emit_slot_in;
   logic [CNT_W-1:0]  recv_ff, recv_in, emit_cnt_ff, emit_cnt_in;
   logic [CNT_W:0]    need;
   logic              frame_last;

   // stores
   logic [PIX_W-1:0]    line_mem [LS_DEPTH];
   logic [2*COEF_W-1:0] coef_mem [KAREA];
   logic [PIX_W-1:0]    pixel_ff;
   logic [PIX_W-1:0]    ls_rd_ff;
   logic [2*COEF_W-1:0] coef_rd_ff;
   logic [LS_AW-1:0]    ls_wr_addr, ls_rd_addr;

   // window MAC
   logic [KW-1:0]   dy_ff, dx_ff;
   logic [KA_W-1:0] k_ff;
   logic            issue_ff, v1_ff, v2_ff;
   logic signed [26:0]      prod_re_ff, prod_im_ff;
   logic signed [ACC_W-1:0] acc_re_ff, acc_im_ff;
   logic signed [11:0] r_s, c_s, off_s, slot_s;

   // magnitude
   logic signed [Q4_W-1:0] q4_re, q4_im;
   logic signed [SQ_W-1:0] sq_re_ff, sq_im_ff;
   logic [SQ_W/2-1:0]      root;
   logic                   sqrt_busy;
   logic [RW-1:0]          root_ext;
   logic [MAG_W-1:0]       mag;

   // output register
   logic             rsp_valid_ff;
   logic [MAG_W-1:0] rsp_mag_ff;
   logic [POS_W-1:0] rsp_col_ff, rsp_row_ff;
   logic             rsp_end_ff;

   // ------------------------------------------------------------------ config
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DIM_W'(FRAME_W_RESET);
         frame_height_ff <= DIM_W'(FRAME_H_RESET);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wr_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (frame_width_ff == '0)                    w_cl = DIM_W'(1);
      else if (frame_width_ff > DIM_W'(WLIMIT))    w_cl = DIM_W'(WLIMIT);
      else                                         w_cl = frame_width_ff;
      if (frame_height_ff == '0)                   h_cl = DIM_W'(1);
      else if (frame_height_ff > DIM_W'(HLIMIT))   h_cl = DIM_W'(HLIMIT);
      else                                         h_cl = frame_height_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_w_ff <= DIM_W'(RST_W);
         lat_h_ff <= DIM_W'(FRAME_H_RESET);
         total_ff <= CNT_W'(RST_TOTAL);
         lag_ff   <= CNT_W'(RST_LAG);
      end else if (cmd.latch_size) begin
         lat_w_ff <= w_cl;
         lat_h_ff <= h_cl;
         total_ff <= CNT_W'(22'(w_cl) * 22'(h_cl));
         lag_ff   <= CNT_W'(KERNEL_RADIUS) * CNT_W'(w_cl) + CNT_W'(KERNEL_RADIUS + 1);
      end
   end

   // --------------------------------------------------------------- positions
   assign frame_last = (emit_cnt_ff + CNT_W'(1)) == total_ff;

   always_comb begin
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      in_slot_in   = in_slot_ff;
      recv_in      = recv_ff;
      emit_col_in  = emit_col_ff;
      emit_row_in  = emit_row_ff;
      emit_slot_in = emit_slot_ff;
      emit_cnt_in  = emit_cnt_ff;
      if (cmd.store_pixel) begin
         recv_in = recv_ff + CNT_W'(1);
         if (DIM_W'(in_col_ff) + DIM_W'(1) >= lat_w_ff) begin
            in_col_in  = '0;
            in_row_in  = in_row_ff + POS_W'(1);
            in_slot_in = (in_slot_ff == SLOT_W'(LS_ROWS - 1)) ? '0 : in_slot_ff + SLOT_W'(1);
         end else begin
            in_col_in = in_col_ff + POS_W'(1);
         end
      end
      if (cmd.emit) begin
         if (frame_last) begin
            // frame done: every position returns to the origin
            in_col_in    = '0;
            in_row_in    = '0;
            in_slot_in   = '0;
            recv_in      = '0;
            emit_col_in  = '0;
            emit_row_in  = '0;
            emit_slot_in = '0;
            emit_cnt_in  = '0;
         end else begin
            emit_cnt_in = emit_cnt_ff + CNT_W'(1);
            if (DIM_W'(emit_col_ff) + DIM_W'(1) >= lat_w_ff) begin
               emit_col_in  = '0;
               emit_row_in  = emit_row_ff + POS_W'(1);
               emit_slot_in = (emit_slot_ff == SLOT_W'(LS_ROWS - 1)) ? '0
                                                                    : emit_slot_ff + SLOT_W'(1);
            end else begin
               emit_col_in = emit_col_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_slot_ff   <= '0;
         recv_ff      <= '0;
         emit_col_ff  <= '0;
         emit_row_ff  <= '0;
         emit_slot_ff <= '0;
         emit_cnt_ff  <= '0;
      end else begin
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_slot_ff   <= in_slot_in;
         recv_ff      <= recv_in;
         emit_col_ff  <= emit_col_in;
         emit_row_ff  <= emit_row_in;
         emit_slot_ff <= emit_slot_in;
         emit_cnt_ff  <= emit_cnt_in;
      end
   end

   // an output is ready once enough of the frame has arrived below it
   always_comb begin
      need = (CNT_W+1)'(emit_cnt_ff) + (CNT_W+1)'(lag_ff);
      if (need > (CNT_W+1)'(total_ff)) need = (CNT_W+1)'(total_ff);
   end

   // ------------------------------------------------------------------ stores
   always_ff @(posedge clock) begin
      if (cmd.take_item) pixel_ff <= req_if.pixel;
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item && req_if.command == CMD_LOAD && 32'(req_if.coef_index) < KAREA) begin
         coef_mem[KA_W'(req_if.coef_index)] <= {req_if.coef_real, req_if.coef_imag};
      end
      coef_rd_ff <= coef_mem[k_ff];
   end

   assign ls_wr_addr = LS_AW'(in_slot_ff) * LS_AW'(MAX_WIDTH) + LS_AW'(in_col_ff);

   always_comb begin
      r_s = $signed(12'(emit_row_ff)) + $signed(12'(dy_ff)) - RAD_S;
      if (r_s < 0) r_s = '0;
      else if (r_s > $signed(12'(lat_h_ff)) - 12'sd1) r_s = $signed(12'(lat_h_ff)) - 12'sd1;
      off_s  = r_s - $signed(12'(emit_row_ff));
      slot_s = $signed(12'(emit_slot_ff)) + off_s;
      if (slot_s < 0) slot_s = slot_s + ROWS_S;
      else if (slot_s >= ROWS_S) slot_s = slot_s - ROWS_S;
      c_s = $signed(12'(emit_col_ff)) + $signed(12'(dx_ff)) - RAD_S;
      if (c_s < 0) c_s = '0;
      else if (c_s > $signed(12'(lat_w_ff)) - 12'sd1) c_s = $signed(12'(lat_w_ff)) - 12'sd1;
      ls_rd_addr = LS_AW'(slot_s[SLOT_W-1:0]) * LS_AW'(MAX_WIDTH) + LS_AW'($unsigned(c_s));
   end

   always_ff @(posedge clock) begin
      if (cmd.store_pixel) line_mem[ls_wr_addr] <= pixel_ff;
      ls_rd_ff <= line_mem[ls_rd_addr];
   end

   // ----------------------------------------------------------------- MAC
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else if (cmd.mac_start) begin
         issue_ff <= 1'b1;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         v1_ff <= issue_ff;
         v2_ff <= v1_ff;
         if (issue_ff && k_ff == KA_W'(KAREA - 1)) issue_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mac_start) begin
         dy_ff     <= '0;
         dx_ff     <= '0;
         k_ff      <= '0;
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else begin
         if (issue_ff) begin
            k_ff <= k_ff + KA_W'(1);
            if (dx_ff == KW'(KSIZE - 1)) begin
               dx_ff <= '0;
               dy_ff <= dy_ff + KW'(1);
            end else begin
               dx_ff <= dx_ff + KW'(1);
            end
         end
         if (v2_ff) begin
            acc_re_ff <= acc_re_ff + ACC_W'(prod_re_ff);
            acc_im_ff <= acc_im_ff + ACC_W'(prod_im_ff);
         end
      end
      prod_re_ff <= $signed({1'b0, ls_rd_ff}) * $signed(coef_rd_ff[2*COEF_W-1:COEF_W]);
      prod_im_ff <= $signed({1'b0, ls_rd_ff}) * $signed(coef_rd_ff[COEF_W-1:0]);
   end

   // ----------------------------------------------------------- magnitude
   // floor to Q.4 is the arithmetic drop of the ten low bits
   assign q4_re = acc_re_ff[ACC_W-1:10];
   assign q4_im = acc_im_ff[ACC_W-1:10];

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sq_re_ff <= q4_re * q4_re;
         sq_im_ff <= q4_im * q4_im;
      end
   end

   gmf_sqrt #(.WIDTH(SQ_W)) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.sqrt_start),
      .operand ($unsigned(sq_re_ff) + $unsigned(sq_im_ff)),
      .busy    (sqrt_busy),
      .root    (root)
   );

   assign root_ext = RW'(root);
   assign mag      = (root_ext > RW'(MAG_MAX)) ? MAG_MAX : MAG_W'(root_ext);

   // -------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_mag_ff <= mag;
         rsp_col_ff <= emit_col_ff;
         rsp_row_ff <= emit_row_ff;
         rsp_end_ff <= frame_last;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.magnitude = rsp_mag_ff;
   assign rsp_if.out_col   = rsp_col_ff;
   assign rsp_if.out_row   = rsp_row_ff;
   assign rsp_if.frame_end = rsp_end_ff;

   // -------------------------------------------------------------- status
   always_comb begin
      status.command    = req_if.command;
      status.recv_zero  = (recv_ff == '0);
      status.frame_full = (recv_ff >= total_ff);
      status.emit_ready = (emit_cnt_ff < total_ff) && ((CNT_W+1)'(recv_ff) >= need);
      status.mac_busy   = issue_ff | v1_ff | v2_ff;
      status.sqrt_busy  = sqrt_busy;
      status.out_free   = !rsp_valid_ff || rsp_if.ready;
      status.frame_last = frame_last;
   end

endmodule
